/* rtl/nhp_frame_decoder_core_defines.svh */
// Assertion macros shared by the frame decoder RTL.
// Depends on nothing; files that assert take it by include.
`ifndef NHP_FRAME_DECODER_CORE_DEFINES_SVH
`define NHP_FRAME_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define NFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while in reset.
`define NFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define NFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/nfd_pkg.sv */
// Types and constants of the frame decoder.
// No dependencies; used by every module of the block but nfd_in_stage.
package nfd_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned BlkW   = 3;

  typedef enum logic [1:0] {
    HDR_DATA0 = 2'b00,
    HDR_DATA1 = 2'b01,
    HDR_END   = 2'b10,
    HDR_LEAD  = 2'b11
  } hdr_e;

  typedef enum logic [1:0] {
    OUT_PROGRESS = 2'd0,
    OUT_COMMAND  = 2'd1,
    OUT_ADDRESS  = 2'd2,
    OUT_ERROR    = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_LEAD = 2'd1,
    ERR_END  = 2'd2,
    ERR_DATA = 2'd3
  } err_e;

  localparam logic [BlkW-1:0] LenLong      = 3'd7;
  localparam logic [BlkW-1:0] BlocksLong   = 3'd5;

  typedef struct packed {
    logic [BlkW-1:0]   blocks_left;
    logic [ValueW-1:0] value_accum;
    logic              restart_pending;
  } state_t;

  typedef struct packed {
    outcome_e          outcome;
    err_e              error_kind;
    logic [3:0]        command_code;
    logic [5:0]        frame_address;
    logic [ValueW-1:0] frame_value;
  } result_t;

endpackage

/* rtl/nfd_in_stage.sv */
// Input register of the frame decoder: holds one received byte.
// Depends on nothing but the handshake signals from the top level.
module nfd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       rx_stall_o,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // Stall only when full and the held byte cannot move on.
  assign rx_stall_o = valid_q && !advance_i;
  assign load       = rx_valid_i && !rx_stall_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

/* rtl/nfd_step.sv */
// Combinational decode of one byte against the current framing state.
// Depends on nfd_pkg for the state and result types.
module nfd_step (
  input  logic            [7:0] byte_i,
  input  nfd_pkg::state_t       state_i,
  output nfd_pkg::state_t       state_o,
  output nfd_pkg::result_t      result_o
);

  logic [nfd_pkg::BlkW-1:0] blk;
  logic [nfd_pkg::BlkW-1:0] len;

  always_comb begin
    // A finished frame, a command or an error wipes the block count first.
    blk = state_i.restart_pending ? '0 : state_i.blocks_left;
    len = byte_i[5:3];

    state_o                 = state_i;
    state_o.blocks_left     = blk;
    result_o.outcome        = nfd_pkg::OUT_PROGRESS;
    result_o.error_kind     = nfd_pkg::ERR_NONE;
    result_o.command_code   = '0;
    result_o.frame_address  = '0;
    result_o.frame_value    = '0;

    case (nfd_pkg::hdr_e'(byte_i[7:6]))
      nfd_pkg::HDR_LEAD: begin
        if (blk != '0) begin
          result_o.error_kind = nfd_pkg::ERR_LEAD;
        end
        if (len inside {3'd0, 3'd1}) begin
          state_o.value_accum   = {{(nfd_pkg::ValueW-4){1'b0}}, byte_i[3:0]};
          state_o.blocks_left   = len;
          result_o.outcome      = nfd_pkg::OUT_COMMAND;
          result_o.command_code = byte_i[3:0];
        end else if (len == nfd_pkg::LenLong) begin
          state_o.value_accum = {{(nfd_pkg::ValueW-4){1'b0}}, byte_i[3:0]};
          state_o.blocks_left = nfd_pkg::BlocksLong;
        end else begin
          state_o.value_accum = {{(nfd_pkg::ValueW-3){1'b0}}, byte_i[2:0]};
          state_o.blocks_left = len - 3'd1;
        end
      end
      nfd_pkg::HDR_END: begin
        if (blk == 3'd1) begin
          result_o.outcome       = nfd_pkg::OUT_ADDRESS;
          result_o.frame_address = byte_i[5:0];
          result_o.frame_value   = state_i.value_accum;
        end else begin
          result_o.outcome    = nfd_pkg::OUT_ERROR;
          result_o.error_kind = nfd_pkg::ERR_END;
        end
      end
      default: begin
        if (blk > 3'd1) begin
          state_o.blocks_left = blk - 3'd1;
          state_o.value_accum = {state_i.value_accum[nfd_pkg::ValueW-8:0], byte_i[6:0]};
        end else begin
          result_o.outcome    = nfd_pkg::OUT_ERROR;
          result_o.error_kind = nfd_pkg::ERR_DATA;
        end
      end
    endcase

    state_o.restart_pending = (result_o.outcome != nfd_pkg::OUT_PROGRESS);
  end

endmodule

/* rtl/nfd_out_stage.sv */
// Result register of the frame decoder with its valid/stall handshake.
// Depends on nfd_pkg for the result type.
module nfd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  nfd_pkg::result_t result_i,
  input  logic             out_stall_i,
  output logic             free_o,
  output logic             out_valid_o,
  output nfd_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  nfd_pkg::result_t result_q;

  // Free when empty or when the held transaction leaves this edge.
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* rtl/nhp_frame_decoder_core.sv */
// Top level of the byte-serial frame decoder: input register, decode step, result register.
// Depends on nfd_pkg, nfd_in_stage, nfd_step, nfd_out_stage and the assertion macros header.
`include "nhp_frame_decoder_core_defines.svh"

// One result per received byte, one byte per clock cycle sustained while the output
// does not stall. A byte's result is registered when it leaves the input register.
// The single decode step updates the framing state (block count, accumulator, restart
// flag) once per byte. Output stall holds the result register and, once the input
// register is also full, stalls the receive side.
module nhp_frame_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [1:0]  error_kind_o,
  output logic [3:0]  command_code_o,
  output logic [5:0]  frame_address_o,
  output logic [31:0] frame_value_o
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             out_free;
  logic             advance;
  nfd_pkg::state_t  state_q, state_d;
  nfd_pkg::result_t step_result;
  nfd_pkg::result_t out_result;

  assign advance = in_valid && out_free;

  nfd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .rx_stall_o (rx_stall_o),
    .valid_o    (in_valid),
    .byte_o     (in_byte)
  );

  nfd_step u_step (
    .byte_i   (in_byte),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (step_result)
  );

  // Commit the framing state only when the byte moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  nfd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (step_result),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign outcome_o       = out_result.outcome;
  assign error_kind_o    = out_result.error_kind;
  assign command_code_o  = out_result.command_code;
  assign frame_address_o = out_result.frame_address;
  assign frame_value_o   = out_result.frame_value;

  `NFD_ASSERT_NXT(a_state_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    $stable(state_q), "framing state changed while the result was stalled")
  `NFD_ASSERT_IMP(a_restart_match, clk_i, rst_ni, out_valid_o,
    state_q.restart_pending == (out_result.outcome != nfd_pkg::OUT_PROGRESS),
    "restart flag disagrees with the last outcome")
  `NFD_ASSERT_IMP(a_stall_full, clk_i, rst_ni, rx_stall_o,
    in_valid && out_valid_o && out_stall_i, "receive stall without a full pipeline")
  `NFD_ASSERT_NXT(a_advance_valid, clk_i, rst_ni, advance,
    out_valid_o, "advanced transaction did not reach the result register")

endmodule

/* sim/nhp_frame_decoder_core_tb.sv */
// Self-checking testbench for nhp_frame_decoder_core: directed rows, then random framed traffic.
// Depends on nfd_pkg and the RTL under rtl/; expected results come from the directed rows or an in-bench decoder.
module nhp_frame_decoder_core_tb;

  localparam int unsigned RandomItems = 1600;
  localparam int unsigned StallLimit  = 2000;

  typedef struct packed {
    logic [7:0]       rx_byte;
    logic             typed;
    logic             wait_drain;
    nfd_pkg::result_t want;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        rx_valid_i = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  outcome_o;
  logic [1:0]  error_kind_o;
  logic [3:0]  command_code_o;
  logic [5:0]  frame_address_o;
  logic [31:0] frame_value_o;

  // Decoder state mirrored from the framing rules
  logic [2:0]  blk_count = '0;
  logic [31:0] accum = '0;
  logic        fresh_next = 1'b0;

  rx_item_t         rx_items[$];
  nfd_pkg::result_t expected_results[$];
  nfd_pkg::result_t oldest;
  nfd_pkg::result_t decoded;
  logic             drain_req = 1'b0;
  logic             mid_drain_done = 1'b0;
  logic             held = 1'b0;
  logic             calm = 1'b0;
  int               idx;
  int               mismatches = 0;
  int               quiet_cycles = 0;

  nhp_frame_decoder_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_stall_o      (rx_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .outcome_o       (outcome_o),
    .error_kind_o    (error_kind_o),
    .command_code_o  (command_code_o),
    .frame_address_o (frame_address_o),
    .frame_value_o   (frame_value_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic nfd_pkg::result_t decode_byte(input logic [7:0] b);
    nfd_pkg::result_t r;
    logic [2:0]       len;
    r = '0;
    r.outcome = nfd_pkg::OUT_PROGRESS;
    r.error_kind = nfd_pkg::ERR_NONE;
    len = b[5:3];
    if (fresh_next) blk_count = '0;
    case (nfd_pkg::hdr_e'(b[7:6]))
      nfd_pkg::HDR_LEAD: begin
        if (blk_count != 3'd0) r.error_kind = nfd_pkg::ERR_LEAD;
        if (len <= 3'd1) begin
          accum = {28'd0, b[3:0]};
          blk_count = len;
          r.outcome = nfd_pkg::OUT_COMMAND;
          r.command_code = b[3:0];
        end else if (len == nfd_pkg::LenLong) begin
          accum = {28'd0, b[3:0]};
          blk_count = nfd_pkg::BlocksLong;
        end else begin
          accum = {29'd0, b[2:0]};
          blk_count = len - 3'd1;
        end
      end
      nfd_pkg::HDR_END: begin
        if (blk_count == 3'd1) begin
          r.outcome = nfd_pkg::OUT_ADDRESS;
          r.frame_address = b[5:0];
          r.frame_value = accum;
        end else begin
          r.outcome = nfd_pkg::OUT_ERROR;
          r.error_kind = nfd_pkg::ERR_END;
        end
      end
      default: begin
        if (blk_count > 3'd1) begin
          blk_count = blk_count - 3'd1;
          accum = {accum[24:0], b[6:0]};
        end else begin
          r.outcome = nfd_pkg::OUT_ERROR;
          r.error_kind = nfd_pkg::ERR_DATA;
        end
      end
    endcase
    fresh_next = (r.outcome != nfd_pkg::OUT_PROGRESS);
    return r;
  endfunction

  task automatic push_item(input logic [7:0] b, input logic typed,
                           input nfd_pkg::result_t want);
    rx_item_t it;
    it.rx_byte = b;
    it.typed = typed;
    it.wait_drain = drain_req;
    it.want = want;
    drain_req = 1'b0;
    rx_items.push_back(it);
  endtask

  task automatic add_predicted(input logic [7:0] b);
    push_item(b, 1'b0, '0);
  endtask

  task automatic add_checked(input logic [7:0] b, input nfd_pkg::outcome_e o,
                             input nfd_pkg::err_e e,
                             input logic [3:0] cmd, input logic [5:0] addr,
                             input logic [31:0] val);
    nfd_pkg::result_t r;
    r.outcome = o;
    r.error_kind = e;
    r.command_code = cmd;
    r.frame_address = addr;
    r.frame_value = val;
    push_item(b, 1'b1, r);
  endtask

  // Emit the first 'keep' bytes of a frame: lead, data bytes, end byte
  task automatic add_frame(input int len, input int keep);
    int ndata;
    int k;
    ndata = (len == 7) ? 4 : len - 2;
    if (keep > 0) add_predicted({2'b11, 3'(len), 3'($urandom)});
    for (k = 0; k < ndata && k + 1 < keep; k++) add_predicted({1'b0, 7'($urandom)});
    if (keep > ndata + 1) add_predicted({2'b10, 6'($urandom)});
  endtask

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  initial begin
    int pick;
    int len;

    // Directed rows
    add_checked(8'h80, nfd_pkg::OUT_ERROR, nfd_pkg::ERR_END, 4'h0, 6'h00, 32'h0);
    add_checked(8'h7F, nfd_pkg::OUT_ERROR, nfd_pkg::ERR_DATA, 4'h0, 6'h00, 32'h0);
    add_checked(8'hC0, nfd_pkg::OUT_COMMAND, nfd_pkg::ERR_NONE, 4'h0, 6'h00, 32'h0);
    add_checked(8'hCF, nfd_pkg::OUT_COMMAND, nfd_pkg::ERR_NONE, 4'hF, 6'h00, 32'h0);
    add_predicted(8'hFF);
    repeat (4) add_predicted(8'h7F);
    add_checked(8'hBF, nfd_pkg::OUT_ADDRESS, nfd_pkg::ERR_NONE, 4'h0, 6'h3F, 32'hFFFF_FFFF);
    add_predicted(8'hD0);
    add_checked(8'h80, nfd_pkg::OUT_ADDRESS, nfd_pkg::ERR_NONE, 4'h0, 6'h00, 32'h0);
    add_predicted(8'hF7);
    add_predicted(8'h00);
    add_predicted(8'hE9);   // lead inside a frame restarts it
    add_predicted(8'hC3);   // command lead inside a frame
    add_predicted(8'hD8);
    add_checked(8'h80, nfd_pkg::OUT_ERROR, nfd_pkg::ERR_END, 4'h0, 6'h00, 32'h0);
    add_predicted(8'hE0);
    add_predicted(8'h55);
    add_predicted(8'h2A);
    add_predicted(8'h81);
    add_predicted(8'hD0);
    add_checked(8'h01, nfd_pkg::OUT_ERROR, nfd_pkg::ERR_DATA, 4'h0, 6'h00, 32'h0);

    // Random part: commands, well-formed frames, some truncated frames and noise
    drain_req = 1'b1;
    while (rx_items.size() < 24 + RandomItems) begin
      if (!mid_drain_done && rx_items.size() >= 900) begin
        drain_req = 1'b1;
        mid_drain_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        add_predicted({4'b1100, 4'($urandom)});
      end else if (pick < 80) begin
        len = $urandom_range(7, 2);
        if (pick < 68) begin
          add_frame(len, 8);
        end else begin
          add_frame(len, $urandom_range(((len == 7) ? 4 : len - 2) + 1, 1));
          add_predicted(8'($urandom));
        end
      end else begin
        add_predicted(8'($urandom));
      end
    end

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    idx = 0;
    while (idx < rx_items.size()) begin
      @(negedge clk_i);
      calm = (idx >= 700 && idx < 1000);
      if (!held) begin
        // Hold off while a drain is requested and results are still due, or at random outside the calm window
        if ((rx_items[idx].wait_drain && expected_results.size() != 0) ||
            (!calm && $urandom_range(99) < 7)) begin
          rx_valid_i <= 1'b0;
        end else begin
          rx_valid_i <= 1'b1;
          rx_byte_i <= rx_items[idx].rx_byte;
          held = 1'b1;
        end
      end
      @(posedge clk_i);
      if (held && !rx_stall_o) begin
        decoded = decode_byte(rx_items[idx].rx_byte);
        expected_results.push_back(rx_items[idx].typed ? rx_items[idx].want : decoded);
        held = 1'b0;
        idx++;
      end
    end
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    calm = 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 7);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, outcome %0d", $time, outcome_o);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("outcome", 32'(oldest.outcome), 32'(outcome_o));
        check_field("error_kind", 32'(oldest.error_kind), 32'(error_kind_o));
        check_field("command_code", 32'(oldest.command_code), 32'(command_code_o));
        check_field("frame_address", 32'(oldest.frame_address), 32'(frame_address_o));
        check_field("frame_value", oldest.frame_value, frame_value_o);
      end
    end
  end

  // Drop the run when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_valid_i && !rx_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, StallLimit);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

/* files.f */
+incdir+rtl
rtl/nfd_pkg.sv
rtl/nfd_in_stage.sv
rtl/nfd_step.sv
rtl/nfd_out_stage.sv
rtl/nhp_frame_decoder_core.sv
sim/nhp_frame_decoder_core_tb.sv
